FILE: hdl/utsf_pkg.sv
package utsf_pkg;

	localparam int CP_W = 21;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] MODE_SANITIZE = 2'd0;
	localparam logic [1:0] MODE_STRIP = 2'd1;
	localparam logic [1:0] MODE_READABLE = 2'd2;
	localparam logic [1:0] MODE_RESET = MODE_STRIP;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       out_last;
	} out_t;

	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [2:0]      nbytes;
		logic            last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hdl/utsf_front.sv
module utsf_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  utsf_pkg::in_t               in_data,
	input  utsf_pkg::q_stat_t           q_stat,
	output logic                        push,
	output utsf_pkg::job_t              push_job
);

	logic [1:0]                mode_q;
	logic [utsf_pkg::CP_W-1:0] acc_q, acc_d;
	logic [1:0]                left_q, left_d;
	logic                      skip_q, skip_d;
	logic                      have;
	logic [utsf_pkg::CP_W-1:0] cp;
	logic                      keep;
	logic [2:0]                nbytes;
	logic                      accept;

	function automatic logic is_garbled(input logic [utsf_pkg::CP_W-1:0] c);
		return (c == 21'h00FFFD) ||
			(c inside {[21'h00E000:21'h00F8FF]}) ||
			(c inside {[21'h00FFF0:21'h00FFFF]}) ||
			(c inside {[21'h00FDD0:21'h00FDEF]}) ||
			(c inside {[21'h0F0000:21'h0FFFFD]}) ||
			(c inside {[21'h100000:21'h10FFFD]});
	endfunction

	function automatic logic is_wanted(input logic [utsf_pkg::CP_W-1:0] c);
		logic r;
		if (c == 21'h0A || c == 21'h09) begin
			r = 1'b1;
		end else if (c < 21'h20 || c == 21'h7F) begin
			r = 1'b0;
		end else if (c inside {[21'h80:21'h9F]}) begin
			r = 1'b0;
		end else begin
			r = !is_garbled(c);
		end
		return r;
	endfunction

	function automatic logic is_readable(input logic [utsf_pkg::CP_W-1:0] c);
		return (c inside {[21'h41:21'h5A]}) ||
			(c inside {[21'h61:21'h7A]}) ||
			(c inside {[21'h30:21'h39]}) ||
			(c inside {[21'h004E00:21'h009FFF]}) ||
			(c inside {[21'h003400:21'h004DBF]}) ||
			(c inside {[21'h003000:21'h00303F]}) ||
			(c inside {[21'h00FF00:21'h00FFEF]});
	endfunction

	function automatic logic [2:0] enc_len(input logic [utsf_pkg::CP_W-1:0] c);
		logic [2:0] r;
		if (c <= 21'h7F) begin
			r = 3'd1;
		end else if (c <= 21'h7FF) begin
			r = 3'd2;
		end else if (c <= 21'hFFFF) begin
			r = 3'd3;
		end else begin
			r = 3'd4;
		end
		return r;
	endfunction

	assign in_ready = !q_stat.full;
	assign accept = in_valid && in_ready;

	always_comb begin
		acc_d = acc_q;
		left_d = left_q;
		skip_d = skip_q;
		have = 1'b0;
		cp = '0;
		if (left_q != 2'd0) begin
			left_d = left_q - 2'd1;
			if (!skip_q && in_data.in_byte[7:6] == 2'b10) begin
				acc_d = {acc_q[utsf_pkg::CP_W-7:0], in_data.in_byte[5:0]};
				if (left_d == 2'd0) begin
					have = 1'b1;
					cp = acc_d;
					acc_d = '0;
				end
			end else begin
				skip_d = (left_d != 2'd0);
			end
		end else if (!in_data.in_byte[7]) begin
			have = 1'b1;
			cp = {13'd0, in_data.in_byte};
		end else if (in_data.in_byte[7:5] == 3'b110) begin
			acc_d = {16'd0, in_data.in_byte[4:0]};
			left_d = 2'd1;
		end else if (in_data.in_byte[7:4] == 4'b1110) begin
			acc_d = {17'd0, in_data.in_byte[3:0]};
			left_d = 2'd2;
		end else if (in_data.in_byte[7:3] == 5'b11110) begin
			acc_d = {18'd0, in_data.in_byte[2:0]};
			left_d = 2'd3;
		end
		if (in_data.in_last) begin
			acc_d = '0;
			left_d = 2'd0;
			skip_d = 1'b0;
		end
	end

	always_comb begin
		case (mode_q)
			utsf_pkg::MODE_SANITIZE: keep = 1'b1;
			utsf_pkg::MODE_STRIP:    keep = is_wanted(cp);
			default:                 keep = is_readable(cp);
		endcase
	end

	assign nbytes = (have && keep) ? enc_len(cp) : 3'd0;
	assign push = accept && (nbytes != 3'd0 || in_data.in_last);
	assign push_job = '{cp: cp, nbytes: nbytes, last: in_data.in_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= utsf_pkg::MODE_RESET;
			acc_q <= '0;
			left_q <= 2'd0;
			skip_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
			if (accept) begin
				acc_q <= acc_d;
				left_q <= left_d;
				skip_q <= skip_d;
			end
		end
	end

endmodule

FILE: hdl/utsf_queue.sv
module utsf_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  utsf_pkg::job_t    push_job,
	input  logic              pop,
	output utsf_pkg::job_t    head_job,
	output utsf_pkg::q_stat_t q_stat
);

	utsf_pkg::job_t                  slot_q [utsf_pkg::QDEPTH];
	logic [utsf_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [utsf_pkg::QCNT_W-1:0]     cnt_q;

	assign head_job = slot_q[rd_q];
	assign q_stat.full = (cnt_q == utsf_pkg::QCNT_W'(utsf_pkg::QDEPTH));
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/utsf_back.sv
module utsf_back (
	input  logic              clk,
	input  logic              arst_n,
	input  utsf_pkg::job_t    head_job,
	input  utsf_pkg::q_stat_t q_stat,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output utsf_pkg::out_t    out_data
);

	logic [1:0]     idx_q;
	logic [1:0]     last_idx;
	logic           final_byte;
	logic           load;
	logic           out_valid_q;
	utsf_pkg::out_t out_data_q;
	logic [7:0]     enc;

	function automatic logic [7:0] enc_byte(input logic [utsf_pkg::CP_W-1:0] c,
		input logic [2:0] n, input logic [1:0] k);
		logic [7:0] r;
		r = 8'd0;
		case (n)
			3'd1: r = c[7:0];
			3'd2: r = (k == 2'd0) ? {3'b110, c[10:6]} : {2'b10, c[5:0]};
			3'd3: begin
				case (k)
					2'd0:    r = {4'b1110, c[15:12]};
					2'd1:    r = {2'b10, c[11:6]};
					default: r = {2'b10, c[5:0]};
				endcase
			end
			3'd4: begin
				case (k)
					2'd0:    r = {5'b11110, c[20:18]};
					2'd1:    r = {2'b10, c[17:12]};
					2'd2:    r = {2'b10, c[11:6]};
					default: r = {2'b10, c[5:0]};
				endcase
			end
			default: r = 8'd0;
		endcase
		return r;
	endfunction

	assign last_idx = (head_job.nbytes == 3'd0) ? 2'd0 : 2'(head_job.nbytes - 3'd1);
	assign final_byte = (idx_q == last_idx);
	assign load = !q_stat.empty && (!out_valid_q || out_ready);
	assign pop = load && final_byte;
	assign enc = enc_byte(head_job.cp, head_job.nbytes, idx_q);

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.out_byte <= enc;
			out_data_q.byte_valid <= (head_job.nbytes != 3'd0);
			out_data_q.out_last <= head_job.last && final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= final_byte ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

FILE: hdl/utf8_sanitize_filter.sv
// UTF-8 sanitizing filter.
// Input channel (in_valid/in_ready/in_data): one text byte per item, in_last on
// the final byte of a text. Output channel (out_valid/out_ready/out_data): one
// cleaned byte per item; byte_valid 0 marks a bare end-of-text item, out_last
// marks the final item of a text.
// cfg_wr_en/cfg_wr_data write filter_mode; the user must do so only while idle,
// which the block does not check. A kept code point is queued as a job,
// then goes byte by byte into the output register. Input takes one byte per
// cycle while in_ready is high, output one per cycle while out_ready is high.
// A four-entry job queue between decoder and encoder absorbs these bursts;
// in_ready drops only while that queue is full.
// Receiver stall: the output register holds its item, the encoder holds its
// place, the queue fills, then the input stalls. Nothing is lost.
// Reset: decoder cleared, queue and output emptied, filter_mode set to 1.
module utf8_sanitize_filter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_wr_data,
	input  logic           in_valid,
	output logic           in_ready,
	input  utsf_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output utsf_pkg::out_t out_data
);

	logic              push;
	logic              pop;
	utsf_pkg::job_t    push_job;
	utsf_pkg::job_t    head_job;
	utsf_pkg::q_stat_t q_stat;

	utsf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_job   (push_job)
	);

	utsf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head_job(head_job),
		.q_stat  (q_stat)
	);

	utsf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.q_stat   (q_stat),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

`ifndef SYNTH
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> !q_stat.full)
		else $error("queue pushed while full");

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.byte_valid) |-> out_data.out_last)
		else $error("bare output item without end mark");

	a_job_sized: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.nbytes <= 3'd4) && (push_job.nbytes != 3'd0 || push_job.last))
		else $error("malformed job entered queue");
`endif

endmodule

FILE: dv/utsf_stream_checker.sv
module utsf_stream_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_wr_data,
	input  logic           in_valid,
	input  logic           in_ready,
	input  utsf_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_ready,
	input  utsf_pkg::out_t out_data,
	output int             fail_count,
	output int             due_count
);

	timeunit 1ns;
	timeprecision 1ps;

	logic [1:0]                mode;
	logic [utsf_pkg::CP_W-1:0] cp_accum;
	logic [1:0]                left;
	logic                      skipping;
	utsf_pkg::out_t            cleaned_due[$];
	utsf_pkg::out_t            want;
	int                        mismatches = 0;

	task automatic flag(string what, int got, int exp_val);
		if (mismatches < 40) begin
			$display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, exp_val);
		end
		mismatches++;
	endtask

	function automatic bit is_garbled(logic [utsf_pkg::CP_W-1:0] cp);
		return cp == 21'hFFFD || (cp >= 21'hE000 && cp <= 21'hF8FF) ||
			(cp >= 21'hFFF0 && cp <= 21'hFFFF) || (cp >= 21'hFDD0 && cp <= 21'hFDEF) ||
			(cp >= 21'hF0000 && cp <= 21'hFFFFD) ||
			(cp >= 21'h100000 && cp <= 21'h10FFFD);
	endfunction

	function automatic bit is_wanted(logic [utsf_pkg::CP_W-1:0] cp);
		if (cp == 21'h0A || cp == 21'h09) return 1'b1;
		if (cp < 21'h20 || cp == 21'h7F) return 1'b0;
		if (cp >= 21'h80 && cp <= 21'h9F) return 1'b0;
		return !is_garbled(cp);
	endfunction

	function automatic bit is_readable(logic [utsf_pkg::CP_W-1:0] cp);
		return (cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A) ||
			(cp >= 21'h30 && cp <= 21'h39) || (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
			(cp >= 21'h3400 && cp <= 21'h4DBF) || (cp >= 21'h3000 && cp <= 21'h303F) ||
			(cp >= 21'hFF00 && cp <= 21'hFFEF);
	endfunction

	function automatic bit keeps(logic [utsf_pkg::CP_W-1:0] cp);
		if (mode == utsf_pkg::MODE_SANITIZE) return 1'b1;
		if (mode == utsf_pkg::MODE_STRIP) return is_wanted(cp);
		return is_readable(cp);
	endfunction

	task automatic decode_and_filter(utsf_pkg::in_t item);
		logic [7:0]                b;
		logic [utsf_pkg::CP_W-1:0] cp;
		logic [7:0]                enc[4];
		bit                        have;
		int                        n;
		utsf_pkg::out_t            r;
		b = item.in_byte;
		cp = '0;
		have = 1'b0;
		n = 0;
		if (left != 2'd0) begin
			if (!skipping && b[7:6] == 2'b10) begin
				cp_accum = {cp_accum[utsf_pkg::CP_W-7:0], b[5:0]};
				left = left - 2'd1;
				if (left == 2'd0) begin
					have = 1'b1;
					cp = cp_accum;
					cp_accum = '0;
				end
			end else begin
				skipping = (left != 2'd1);
				left = left - 2'd1;
			end
		end else if (b[7] == 1'b0) begin
			have = 1'b1;
			cp = {13'd0, b};
		end else if (b[7:5] == 3'b110) begin
			cp_accum = {16'd0, b[4:0]};
			left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			cp_accum = {17'd0, b[3:0]};
			left = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			cp_accum = {18'd0, b[2:0]};
			left = 2'd3;
		end
		if (have && keeps(cp)) begin
			if (cp <= 21'h7F) begin
				enc[0] = cp[7:0];
				n = 1;
			end else if (cp <= 21'h7FF) begin
				enc[0] = {3'b110, cp[10:6]};
				enc[1] = {2'b10, cp[5:0]};
				n = 2;
			end else if (cp <= 21'hFFFF) begin
				enc[0] = {4'b1110, cp[15:12]};
				enc[1] = {2'b10, cp[11:6]};
				enc[2] = {2'b10, cp[5:0]};
				n = 3;
			end else begin
				enc[0] = {5'b11110, cp[20:18]};
				enc[1] = {2'b10, cp[17:12]};
				enc[2] = {2'b10, cp[11:6]};
				enc[3] = {2'b10, cp[5:0]};
				n = 4;
			end
		end
		for (int i = 0; i < n; i++) begin
			r.out_byte = enc[i];
			r.byte_valid = 1'b1;
			r.out_last = item.in_last && (i == n - 1);
			cleaned_due.insert(cleaned_due.size(), r);
		end
		if (item.in_last) begin
			cp_accum = '0;
			left = 2'd0;
			skipping = 1'b0;
			if (n == 0) begin
				r.out_byte = 8'h00;
				r.byte_valid = 1'b0;
				r.out_last = 1'b1;
				cleaned_due.insert(cleaned_due.size(), r);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = utsf_pkg::MODE_RESET;
			cp_accum = '0;
			left = 2'd0;
			skipping = 1'b0;
			cleaned_due.delete();
			due_count <= 0;
			fail_count <= mismatches;
		end else begin
			if (out_valid && out_ready) begin
				if (cleaned_due.size() == 0) begin
					flag("unexpected item", out_data, 0);
				end else begin
					want = cleaned_due.pop_front();
					if (out_data.out_byte !== want.out_byte)
						flag("out_byte", out_data.out_byte, want.out_byte);
					if (out_data.byte_valid !== want.byte_valid)
						flag("byte_valid", out_data.byte_valid, want.byte_valid);
					if (out_data.out_last !== want.out_last)
						flag("out_last", out_data.out_last, want.out_last);
				end
			end
			if (in_valid && in_ready) decode_and_filter(in_data);
			if (cfg_wr_en) mode = cfg_wr_data;
			due_count <= cleaned_due.size();
			fail_count <= mismatches;
		end
	end

endmodule

FILE: dv/tb.sv
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT = 400000;
	localparam int RANDOM_ITEMS = 360;
	localparam int NPHASES = 5;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	logic           clk;
	logic           arst_n;
	logic           cfg_wr_en;
	logic [1:0]     cfg_wr_data;
	logic           in_valid;
	logic           in_ready;
	utsf_pkg::in_t  in_data;
	logic           out_valid;
	logic           out_ready;
	utsf_pkg::out_t out_data;
	int             fail_count;
	int             due_count;

	int         cycles = 0;
	int         burst_left = 0;
	int         phase_sent;
	logic [7:0] stall_pat;
	int         stall_style;
	int         stall_span;
	logic [7:0] text_q[$];
	logic [7:0] directed_bytes[25];
	logic [1:0] phase_modes[NPHASES];

	utf8_sanitize_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	utsf_stream_checker stream_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.due_count(due_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_style <= $urandom_range(0, 3);
			stall_span <= $urandom_range(20, 120);
			stall_pat <= 8'($urandom) | 8'h01;
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_style)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= stall_pat[cycles % 8];
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] lead_byte(int ncont);
		case (ncont)
			1: return 8'hC0 | 8'($urandom_range(0, 31));
			2: return 8'hE0 | 8'($urandom_range(0, 15));
			default: return 8'hF0 | 8'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic append_byte(logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endtask

	task automatic send_byte(logic [7:0] b, logic last);
		int idle;
		utsf_pkg::in_t item;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (idle != 0) begin
				in_valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
		end
		item.in_byte = b;
		item.in_last = last;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		phase_sent++;
	endtask

	task automatic add_char();
		int kind;
		int ncont;
		logic [7:0] lead;
		kind = $urandom_range(0, 11);
		case (kind)
			0, 1: append_byte(8'($urandom_range(0, 127)));
			2: begin
				case ($urandom_range(0, 2))
					0: append_byte(8'h41 + 8'($urandom_range(0, 25)));
					1: append_byte(8'h61 + 8'($urandom_range(0, 25)));
					default: append_byte(8'h30 + 8'($urandom_range(0, 9)));
				endcase
			end
			3: begin
				append_byte(lead_byte(1));
				append_byte(cont_byte());
			end
			4, 5, 6: begin
				case ($urandom_range(0, 5))
					0: lead = 8'hE3;
					1: lead = 8'hE4 + 8'($urandom_range(0, 5));
					2: lead = 8'hEF;
					3: lead = 8'hEE;
					4: lead = 8'hED;
					default: lead = lead_byte(2);
				endcase
				append_byte(lead);
				if (lead == 8'hEF) append_byte(8'($urandom_range(8'hB4, 8'hBF)));
				else append_byte(cont_byte());
				append_byte(cont_byte());
			end
			7, 8: begin
				append_byte(lead_byte(3));
				repeat (3) append_byte(cont_byte());
			end
			9: append_byte(8'($urandom_range(0, 255)));
			10: begin
				ncont = $urandom_range(1, 3);
				append_byte(lead_byte(ncont));
				if ($urandom_range(0, 1)) append_byte(8'($urandom_range(0, 127)));
				else append_byte(8'($urandom_range(192, 255)));
				repeat (ncont - 1) append_byte(8'($urandom_range(0, 255)));
			end
			default: begin
				if ($urandom_range(0, 1)) append_byte(cont_byte());
				else append_byte(8'($urandom_range(8'hF8, 8'hFF)));
			end
		endcase
	endtask

	task automatic send_text();
		int ncont;
		text_q.delete();
		repeat ($urandom_range(1, 10)) add_char();
		if ($urandom_range(0, 5) == 0) begin
			ncont = $urandom_range(1, 3);
			append_byte(lead_byte(ncont));
			repeat ($urandom_range(0, ncont - 1)) append_byte(cont_byte());
		end
		foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
	endtask

	task automatic set_mode(logic [1:0] m);
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 2'd0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		stall_span = 0;
		stall_style = 0;
		stall_pat = 8'hFF;
		directed_bytes = '{8'h41, 8'h00, 8'h0A, 8'h7F, 8'hC2, 8'h80, 8'hE4, 8'hB8, 8'h80,
			8'hEF, 8'hBF, 8'hBD, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hC0, 8'h80,
			8'hE4, 8'h41, 8'h42, 8'hFF, 8'h80, 8'hE4, 8'hB8};
		phase_modes = '{utsf_pkg::MODE_SANITIZE, utsf_pkg::MODE_READABLE, MODE_SPARE,
			utsf_pkg::MODE_STRIP, utsf_pkg::MODE_SANITIZE};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed text in the reset mode, cut off inside a sequence at its end
		phase_sent = 0;
		foreach (directed_bytes[i]) send_byte(directed_bytes[i], i == 24);

		foreach (phase_modes[p]) begin
			set_mode(phase_modes[p]);
			phase_sent = 0;
			while (phase_sent < RANDOM_ITEMS / NPHASES) send_text();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
